// ----- rtl/sps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the sync pulse timebase and jitter statistics
// block: beat payloads, opcodes, controller states, command and status groups.
// ----------------------------------------------------------------------------
package sps_pkg;

  typedef enum logic [1:0] {
    OP_EDGE     = 2'd0,
    OP_ANCHOR   = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_SNAPSHOT = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] now_us;
    logic [31:0] edge_start_us;
  } item_t;

  typedef struct packed {
    logic [31:0] synced_time_us;
    logic [31:0] pulse_total;
    logic [23:0] mean_latency_q8;
    logic [23:0] jitter_q8;
    logic        stats_valid;
  } result_t;

  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int SUM_W      = 48;
  localparam int SQSUM_W    = 64;
  localparam int PROD_W     = 96;
  localparam int STAT_W     = 24;
  localparam int MUL_Q_W    = 48;
  localparam int MUL_STEP_W = 6;

  localparam logic [MUL_STEP_W-1:0] MUL_A_STEPS = 6'd32;
  localparam logic [MUL_STEP_W-1:0] MUL_B_STEPS = 6'd48;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_EDGE_SQ,
    S_EDGE_ACC,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_MUL_A_GO,
    S_MUL_A_WAIT,
    S_MUL_B_GO,
    S_MUL_B_WAIT,
    S_DIFF,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_JIT_GO,
    S_JIT_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic edge_lat;
    logic edge_sq;
    logic edge_acc;
    logic anchor;
    logic clear;
    logic snap;
    logic mean_go;
    logic mul_a_go;
    logic mul_b_go;
    logic diff;
    logic sqrt_go;
    logic jit_go;
    logic mean_save;
    logic jit_save;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    cnt_zero;
    logic    mul_done;
    logic    a_gt_b;
    logic    sqrt_done;
    logic    div_done;
  } status_t;

endpackage

// ----- rtl/sync_pulse_timebase_and_jitter_stats.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_pulse_timebase_and_jitter_stats
// Sync edges advance a synced microsecond timebase and feed latency count,
// mean and standard deviation; anchor, clear and snapshot opcodes control it.
//
// One beat is taken at a time and each beat gives exactly one result beat.
// An edge's result passes through latency clip, square, accumulate and
// output load after acceptance; anchor, clear and a snapshot without pulses
// go straight to the output load. The next beat can be taken in the cycle
// after the result is loaded. A snapshot with pulses runs the shared
// restoring divider for the mean, the shift-add multiplier twice for the
// variance numerator, then the digit-by-digit root and the divider again
// for the jitter; when the variance numerator is not positive, the root
// and the second division are skipped. A pending result beat is held in
// an output register, so the next beat is taken while it waits; a new
// result is loaded only once the previous one has been taken.
// ----------------------------------------------------------------------------
module sync_pulse_timebase_and_jitter_stats
  import sps_pkg::*;
#(
  parameter int LATENCY_BITS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  cmd_t    cmd;
  status_t st;

  sps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .cmd          (cmd)
  );

  sps_dp #(
    .LATENCY_BITS  (LATENCY_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .st     (st),
    .result (result)
  );

endmodule

// ----- rtl/sps_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_div
// Restoring divider, one quotient bit per cycle, divisor of count width.
// ----------------------------------------------------------------------------
module sps_div
  import sps_pkg::*;
#(
  parameter int DIVIDEND_W = 56
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [COUNT_W-1:0]    divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_W-1:0]     steps;
  logic [COUNT_W-1:0]    rem;
  logic [COUNT_W-1:0]    dsr;
  logic [DIVIDEND_W-1:0] dvd;
  logic [COUNT_W:0]      trial;
  logic [COUNT_W:0]      trial_sub;
  logic                  fits;

  assign trial     = {rem, dvd[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign fits      = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(DIVIDEND_W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
    end else if (steps != '0) begin
      rem <= fits ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
      dvd <= {dvd[DIVIDEND_W-2:0], fits};
    end
  end

  assign done     = (steps == '0);
  assign quotient = dvd;

endmodule

// ----- rtl/sps_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_sqrt
// Integer square root, digit by digit, one root bit per cycle (floor result).
// ----------------------------------------------------------------------------
module sps_sqrt
  import sps_pkg::*;
#(
  parameter int ROOT_W = 56
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int WORK_W = ROOT_W + 4;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [STEP_W-1:0] steps;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem;
  logic [WORK_W-1:0] t;
  logic [WORK_W-1:0] trial;
  logic [WORK_W-1:0] t_sub;
  logic              fits;

  assign t     = {rem, rad_q[RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign t_sub = t - trial;
  assign fits  = (t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(ROOT_W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_q <= radicand;
      rem   <= '0;
      root  <= '0;
    end else if (steps != '0) begin
      rad_q <= rad_q << 2;
      rem   <= fits ? t_sub[REM_W-1:0] : t[REM_W-1:0];
      root  <= {root[ROOT_W-2:0], fits};
    end
  end

  assign done = (steps == '0);

endmodule

// ----- rtl/sps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_dp
// Datapath: timebase and statistic registers, latency square, shift-add
// multiplier for the variance numerator, shared divider and root unit.
// ----------------------------------------------------------------------------
module sps_dp
  import sps_pkg::*;
#(
  parameter int LATENCY_BITS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output status_t st,
  output result_t result
);

  localparam int DIV_W     = SUM_W + FRACTION_BITS;
  localparam int ROOT_W    = DIV_W;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQ_W      = 2 * LATENCY_BITS;
  localparam int SUM_EXT_W = SUM_W + 1;
  localparam int SQ_EXT_W  = SQSUM_W + 1;
  localparam logic [LATENCY_BITS-1:0] LAT_MAX = '1;

  item_t                   item_q;
  logic [LATENCY_BITS-1:0] lat_q;
  logic [SQ_W-1:0]         sq_q;

  logic [TIME_W-1:0]  synced_base;
  logic [TIME_W-1:0]  last_edge_time;
  logic [COUNT_W-1:0] pulse_counter;
  logic [SUM_W-1:0]   latency_sum;
  logic [SQSUM_W-1:0] latency_square_sum;

  logic [COUNT_W-1:0] cnt_c;
  logic [SUM_W-1:0]   sum_c;
  logic [SQSUM_W-1:0] sqsum_c;

  logic [PROD_W-1:0]     mul_acc;
  logic [PROD_W-1:0]     mul_m;
  logic [MUL_Q_W-1:0]    mul_q;
  logic [MUL_STEP_W-1:0] mul_steps;
  logic [PROD_W-1:0]     a_q;
  logic [PROD_W-1:0]     n_q;

  logic [STAT_W-1:0] mean_q;
  logic [STAT_W-1:0] jit_q;

  logic [TIME_W-1:0]       lat_raw;
  logic [LATENCY_BITS-1:0] lat_clip;
  logic [TIME_W-1:0]       elapsed;
  logic [SUM_EXT_W-1:0]    sum_add;
  logic [SQ_EXT_W-1:0]     sqsum_add;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_quot;
  logic              div_done;
  logic [RAD_W-1:0]  sqrt_rad;
  logic [ROOT_W-1:0] sqrt_root;
  logic              sqrt_done;

  function automatic logic [STAT_W-1:0] sat_stat(input logic [DIV_W-1:0] q);
    if (|q[DIV_W-1:STAT_W]) begin
      return '1;
    end
    return q[STAT_W-1:0];
  endfunction

  assign lat_raw   = item_q.now_us - item_q.edge_start_us;
  assign lat_clip  = (lat_raw > TIME_W'(LAT_MAX)) ? LAT_MAX : lat_raw[LATENCY_BITS-1:0];
  assign elapsed   = item_q.now_us - last_edge_time;
  assign sum_add   = {1'b0, latency_sum} + SUM_EXT_W'(lat_q);
  assign sqsum_add = {1'b0, latency_square_sum} + SQ_EXT_W'(sq_q);

  // timebase and running statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      synced_base        <= '0;
      last_edge_time     <= '0;
      pulse_counter      <= '0;
      latency_sum        <= '0;
      latency_square_sum <= '0;
    end else begin
      if (cmd.edge_acc) begin
        synced_base    <= synced_base + elapsed;
        last_edge_time <= item_q.now_us;
        // a full pulse count freezes the statistics
        if (pulse_counter != '1) begin
          pulse_counter      <= pulse_counter + 1'b1;
          latency_sum        <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          latency_square_sum <= sqsum_add[SQSUM_W] ? '1 : sqsum_add[SQSUM_W-1:0];
        end
      end
      if (cmd.anchor) begin
        last_edge_time <= item_q.now_us;
        synced_base    <= '0;
      end
      if (cmd.clear || cmd.snap) begin
        pulse_counter      <= '0;
        latency_sum        <= '0;
        latency_square_sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_q <= item;
      cnt_c  <= '0;
      mean_q <= '0;
      jit_q  <= '0;
    end
    if (cmd.edge_lat) begin
      lat_q <= lat_clip;
    end
    if (cmd.edge_sq) begin
      sq_q <= SQ_W'(lat_q) * SQ_W'(lat_q);
    end
    if (cmd.snap) begin
      cnt_c   <= pulse_counter;
      sum_c   <= latency_sum;
      sqsum_c <= latency_square_sum;
    end
    if (cmd.mean_save) begin
      mean_q <= sat_stat(div_quot);
    end
    if (cmd.jit_save) begin
      jit_q <= sat_stat(div_quot);
    end
    if (cmd.diff) begin
      n_q <= a_q - mul_acc;
    end
  end

  // shift-add multiplier: count * square sum, then sum * sum
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_steps <= '0;
    end else if (cmd.mul_a_go) begin
      mul_steps <= MUL_A_STEPS;
    end else if (cmd.mul_b_go) begin
      mul_steps <= MUL_B_STEPS;
    end else if (mul_steps != '0) begin
      mul_steps <= mul_steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_a_go) begin
      mul_acc <= '0;
      mul_m   <= PROD_W'(sqsum_c);
      mul_q   <= MUL_Q_W'(cnt_c);
    end else if (cmd.mul_b_go) begin
      a_q     <= mul_acc;
      mul_acc <= '0;
      mul_m   <= PROD_W'(sum_c);
      mul_q   <= MUL_Q_W'(sum_c);
    end else if (mul_steps != '0) begin
      mul_acc <= mul_acc + (mul_q[0] ? mul_m : '0);
      mul_m   <= mul_m << 1;
      mul_q   <= mul_q >> 1;
    end
  end

  assign div_start    = cmd.mean_go || cmd.jit_go;
  assign div_dividend = cmd.mean_go ? (DIV_W'(sum_c) << FRACTION_BITS) : sqrt_root;
  assign sqrt_rad     = RAD_W'(n_q) << (2 * FRACTION_BITS);

  sps_div #(
    .DIVIDEND_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_c),
    .done     (div_done),
    .quotient (div_quot)
  );

  sps_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_go),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.synced_time_us  <= synced_base + elapsed;
      result.pulse_total     <= cnt_c;
      result.mean_latency_q8 <= mean_q;
      result.jitter_q8       <= jit_q;
      result.stats_valid     <= (cnt_c != '0);
    end
  end

  assign st.op        = item_q.opcode;
  assign st.cnt_zero  = (pulse_counter == '0);
  assign st.mul_done  = (mul_steps == '0);
  assign st.a_gt_b    = (a_q > mul_acc);
  assign st.sqrt_done = sqrt_done;
  assign st.div_done  = div_done;

endmodule

// ----- rtl/sps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_ctrl
// Controller: takes one beat at a time, sequences the datapath and holds the
// result beat until the output side takes it.
// ----------------------------------------------------------------------------
module sps_ctrl
  import sps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  output logic    result_valid,
  input  logic    result_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   result_free;

  assign result_free = !result_valid || !result_stall;
  assign item_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (st.op)
          OP_EDGE:     state_next = S_EDGE_SQ;
          OP_ANCHOR:   state_next = S_DONE;
          OP_CLEAR:    state_next = S_DONE;
          OP_SNAPSHOT: state_next = st.cnt_zero ? S_DONE : S_MEAN_GO;
        endcase
      end
      S_EDGE_SQ:    state_next = S_EDGE_ACC;
      S_EDGE_ACC:   state_next = S_DONE;
      S_MEAN_GO:    state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: begin
        if (st.div_done) state_next = S_MUL_A_GO;
      end
      S_MUL_A_GO:   state_next = S_MUL_A_WAIT;
      S_MUL_A_WAIT: begin
        if (st.mul_done) state_next = S_MUL_B_GO;
      end
      S_MUL_B_GO:   state_next = S_MUL_B_WAIT;
      S_MUL_B_WAIT: begin
        if (st.mul_done) state_next = S_DIFF;
      end
      // a zero or negative numerator leaves the jitter at zero
      S_DIFF:       state_next = st.a_gt_b ? S_SQRT_GO : S_DONE;
      S_SQRT_GO:    state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (st.sqrt_done) state_next = S_JIT_GO;
      end
      S_JIT_GO:     state_next = S_JIT_WAIT;
      S_JIT_WAIT: begin
        if (st.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (result_free) state_next = S_IDLE;
      end
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:       cmd.take = item_valid;
      S_DECODE: begin
        cmd.edge_lat = (st.op == OP_EDGE);
        cmd.anchor   = (st.op == OP_ANCHOR);
        cmd.clear    = (st.op == OP_CLEAR);
        cmd.snap     = (st.op == OP_SNAPSHOT);
      end
      S_EDGE_SQ:    cmd.edge_sq = 1'b1;
      S_EDGE_ACC:   cmd.edge_acc = 1'b1;
      S_MEAN_GO:    cmd.mean_go = 1'b1;
      S_MEAN_WAIT:  cmd.mean_save = st.div_done;
      S_MUL_A_GO:   cmd.mul_a_go = 1'b1;
      S_MUL_A_WAIT: cmd = '0;
      S_MUL_B_GO:   cmd.mul_b_go = 1'b1;
      S_MUL_B_WAIT: cmd = '0;
      S_DIFF:       cmd.diff = 1'b1;
      S_SQRT_GO:    cmd.sqrt_go = 1'b1;
      S_SQRT_WAIT:  cmd = '0;
      S_JIT_GO:     cmd.jit_go = 1'b1;
      S_JIT_WAIT:   cmd.jit_save = st.div_done;
      S_DONE:       cmd.load_out = result_free;
      default:      cmd = '0;
    endcase
  end

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (st.mul_done && st.div_done && st.sqrt_done))
    else $error("arithmetic unit busy while controller idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result beat raised outside done state");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && result_free) |=> (result_valid && state == S_IDLE))
    else $error("done state did not hand over its result beat");

endmodule

// ----- bench/sync_pulse_timebase_and_jitter_stats_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_pulse_timebase_and_jitter_stats_tb
// Self-checking bench for the sync pulse timebase and latency statistics
// block. A short directed list covers the field extremes, latency wrap and
// clip, the anchor, clear, and empty and single-pulse snapshots. Random
// bursts of sync edges with a rising microsecond clock follow, each ended by
// a snapshot or a clear, with random noise beats mixed in. The bench keeps
// its own copy of the timebase and statistics and checks every result beat
// in order, under four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module sync_pulse_timebase_and_jitter_stats_tb;
  import sps_pkg::*;

  localparam int LAT_BITS   = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PHASE_BEATS = 357;
  localparam int DRAIN_CYCLES = 400;
  localparam int STUCK_LIMIT  = 20000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  sync_pulse_timebase_and_jitter_stats #(
    .LATENCY_BITS (LAT_BITS),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t   sync_items[$];
  result_t expected_readouts[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int mismatches      = 0;
  int readouts_checked = 0;
  int full_snapshots  = 0;
  int op_seen[4];
  int stuck_cycles    = 0;

  // shadow copy of the block state
  logic [31:0] shadow_base      = '0;
  logic [31:0] shadow_last_edge = '0;
  logic [31:0] shadow_count     = '0;
  logic [47:0] shadow_sum       = '0;
  logic [63:0] shadow_sqsum     = '0;

  function automatic result_t predict_readout(item_t it);
    result_t     r;
    logic [31:0] lat;
    logic [63:0] sq;
    logic [48:0] sum_next;
    logic [64:0] sq_next;
    logic [31:0] cnt;
    logic [47:0] sum;
    logic [63:0] sqs;
    logic [63:0] mean;
    logic [63:0] root;
    logic [63:0] cand;
    logic [63:0] jit;
    logic [127:0] num_a;
    logic [127:0] num_b;
    logic [127:0] num;
    int bit_i;
    r = '0;
    case (it.opcode)
      OP_EDGE: begin
        lat = it.now_us - it.edge_start_us;
        if (lat > (32'd1 << LAT_BITS) - 32'd1) lat = (32'd1 << LAT_BITS) - 32'd1;
        shadow_base = shadow_base + (it.now_us - shadow_last_edge);
        shadow_last_edge = it.now_us;
        if (shadow_count != 32'hFFFF_FFFF) begin
          sq = 64'(lat) * 64'(lat);
          shadow_count = shadow_count + 32'd1;
          sum_next = {1'b0, shadow_sum} + 49'(lat);
          shadow_sum = sum_next[48] ? '1 : sum_next[47:0];
          sq_next = {1'b0, shadow_sqsum} + 65'(sq);
          shadow_sqsum = sq_next[64] ? '1 : sq_next[63:0];
        end
      end
      OP_ANCHOR: begin
        shadow_last_edge = it.now_us;
        shadow_base = '0;
      end
      OP_CLEAR: begin
        shadow_count = '0;
        shadow_sum   = '0;
        shadow_sqsum = '0;
      end
      default: begin
        cnt = shadow_count;
        sum = shadow_sum;
        sqs = shadow_sqsum;
        shadow_count = '0;
        shadow_sum   = '0;
        shadow_sqsum = '0;
        if (cnt != 0) begin
          r.pulse_total = cnt;
          r.stats_valid = 1'b1;
          mean = ({16'b0, sum} << FRAC_BITS) / {32'b0, cnt};
          r.mean_latency_q8 = (mean > 64'hFF_FFFF) ? '1 : mean[23:0];
          num_a = 128'(cnt) * 128'(sqs);
          num_b = 128'(sum) * 128'(sum);
          if (num_a > num_b) begin
            num = (num_a - num_b) << (2 * FRAC_BITS);
            // bitwise integer square root, high bit first
            root = '0;
            for (bit_i = 63; bit_i >= 0; bit_i--) begin
              cand = root | (64'd1 << bit_i);
              if (128'(cand) * 128'(cand) <= num) root = cand;
            end
            jit = root / {32'b0, cnt};
            r.jitter_q8 = (jit > 64'hFF_FFFF) ? '1 : jit[23:0];
          end
        end
      end
    endcase
    r.synced_time_us = shadow_base + (it.now_us - shadow_last_edge);
    return r;
  endfunction

  // sender: one beat in flight, held while stalled
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_readouts.push_back(predict_readout(item));
        op_seen[item.opcode]++;
      end
      if (!item_valid || !item_stall) begin
        if (sync_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          item       <= sync_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall, in-order compare
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_readouts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result beat: %h", $realtime, result);
        end else begin
          want = expected_readouts.pop_front();
          readouts_checked++;
          if (result.stats_valid) full_snapshots++;
          if (result.synced_time_us !== want.synced_time_us ||
              result.pulse_total !== want.pulse_total ||
              result.mean_latency_q8 !== want.mean_latency_q8 ||
              result.jitter_q8 !== want.jitter_q8 ||
              result.stats_valid !== want.stats_valid) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("[%0t] mismatch (expected/actual): time %h/%h total %h/%h ",
                     $realtime,
                     want.synced_time_us, result.synced_time_us,
                     want.pulse_total, result.pulse_total);
              $display("mean %h/%h jitter %h/%h valid %b/%b",
                       want.mean_latency_q8, result.mean_latency_q8,
                       want.jitter_q8, result.jitter_q8,
                       want.stats_valid, result.stats_valid);
            end
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL sync_pulse_timebase_and_jitter_stats");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_item(opcode_t op, logic [31:0] now_us, logic [31:0] start_us);
    item_t it;
    it.opcode        = op;
    it.now_us        = now_us;
    it.edge_start_us = start_us;
    sync_items.push_back(it);
  endtask

  function automatic logic [31:0] pick_latency();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(0, 300);
    if (roll < 90) return $urandom_range(0, 70000);
    return $urandom;
  endfunction

  // a run of edges at about 1 kHz closed by a snapshot, sometimes a clear
  task automatic add_burst(ref logic [31:0] wall_us, ref int added);
    int n_edges;
    int k;
    if ($urandom_range(3) == 0) begin
      wall_us = wall_us + $urandom_range(1, 2000);
      push_item(OP_ANCHOR, wall_us, $urandom);
      added++;
    end
    n_edges = $urandom_range(1, 12);
    for (k = 0; k < n_edges; k++) begin
      if ($urandom_range(19) == 0) wall_us = wall_us + $urandom;
      else wall_us = wall_us + $urandom_range(500, 1500);
      push_item(OP_EDGE, wall_us, wall_us - pick_latency());
      added++;
    end
    wall_us = wall_us + $urandom_range(0, 900);
    if ($urandom_range(7) == 0) push_item(OP_CLEAR, wall_us, $urandom);
    else push_item(OP_SNAPSHOT, wall_us, $urandom);
    added++;
  endtask

  task automatic wait_drained();
    while (sync_items.size() != 0 || item_valid || expected_readouts.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int phase;
    int added;
    int k;
    logic [31:0] wall_us;
    int sender_pct[4];
    int stall_pct[4];
    sender_pct = '{0, 66, 0, 9};
    stall_pct  = '{0, 0, 66, 9};
    foreach (op_seen[i]) op_seen[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed beats
    push_item(OP_SNAPSHOT, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_EDGE,     32'h0000_0064, 32'h0000_0064);
    push_item(OP_EDGE,     32'hFFFF_FFFF, 32'h0000_0000);
    push_item(OP_EDGE,     32'h0000_0005, 32'hFFFF_FFFF);
    push_item(OP_EDGE,     32'h0001_0004, 32'h0000_0005);
    push_item(OP_EDGE,     32'h0001_0016, 32'h0000_0016);
    push_item(OP_EDGE,     32'h0000_0000, 32'hFFFF_FFFF);
    push_item(OP_SNAPSHOT, 32'h0001_0100, 32'hFFFF_FFFF);
    push_item(OP_SNAPSHOT, 32'h0001_0200, 32'h0000_0000);
    push_item(OP_EDGE,     32'h0001_0300, 32'h0001_02F0);
    push_item(OP_SNAPSHOT, 32'h0001_0400, 32'h0000_0000);
    push_item(OP_ANCHOR,   32'h8000_0000, 32'hFFFF_FFFF);
    push_item(OP_EDGE,     32'h8000_0100, 32'h8000_00F0);
    push_item(OP_EDGE,     32'h8000_0500, 32'h8000_04F0);
    push_item(OP_EDGE,     32'h8000_0900, 32'h8000_08F0);
    push_item(OP_SNAPSHOT, 32'h8000_0A00, 32'h0000_0000);
    push_item(OP_EDGE,     32'h8000_0B00, 32'h8000_0A00);
    push_item(OP_CLEAR,    32'h0000_0000, 32'hFFFF_FFFF);
    push_item(OP_SNAPSHOT, 32'h8000_0C00, 32'h0000_0000);
    push_item(OP_ANCHOR,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(OP_EDGE,     32'h0000_03E7, 32'h0000_0000);
    push_item(OP_CLEAR,    32'hFFFF_FFFF, 32'h0000_0000);
    push_item(OP_EDGE,     32'h0000_07CF, 32'h0000_0000);
    push_item(OP_SNAPSHOT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    wall_us = $urandom;
    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct = sender_pct[phase];
      recv_stall_pct  = stall_pct[phase];
      added = 0;
      while (added < PHASE_BEATS) begin
        if ($urandom_range(99) < 80) begin
          add_burst(wall_us, added);
        end else begin
          // noise beats
          for (k = 0; k < $urandom_range(1, 4); k++) begin
            push_item(opcode_t'($urandom_range(3)), $urandom, $urandom);
            added++;
          end
        end
      end
      // sender holds off until every result is back
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_readouts.size() != 0) mismatches++;
    $display("covered %0d edges, %0d anchors, %0d clears, %0d snapshots (%0d with pulses)",
             op_seen[OP_EDGE], op_seen[OP_ANCHOR], op_seen[OP_CLEAR],
             op_seen[OP_SNAPSHOT], full_snapshots);
    $display("%0d result beats checked, %0d mismatches", readouts_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS sync_pulse_timebase_and_jitter_stats");
    end else begin
      $display("FAIL sync_pulse_timebase_and_jitter_stats");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sps_pkg.sv
rtl/sps_div.sv
rtl/sps_sqrt.sv
rtl/sps_dp.sv
rtl/sps_ctrl.sv
rtl/sync_pulse_timebase_and_jitter_stats.sv
bench/sync_pulse_timebase_and_jitter_stats_tb.sv
